// ===== rtl/cpp_pkg.sv =====
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared widths, register codes, sideband type and the Q1.15 sine table
// used by the camera point projection pipeline.
// ----------------------------------------------------------------------------
package cpp_pkg;

   localparam int COORD_W   = 16;   // world and screen coordinates
   localparam int REL_W     = 17;   // point minus camera
   localparam int ANGLE_W   = 9;
   localparam int SIZE_W    = 12;
   localparam int TRIG_W    = 16;   // Q1.15
   localparam int FOCAL_W   = 16;
   localparam int FOCAL_DEFAULT = 1000;
   localparam int CSR_IDX_W = 3;

   localparam int P1_W  = REL_W + TRIG_W;      // rel * trig
   localparam int LX_W  = P1_W + 1;            // sum of two products
   localparam int P2_W  = LX_W + TRIG_W;       // rotated z * trig
   localparam int L30_W = P2_W + 2;            // Q.30 sum plus rounding headroom
   localparam int L_W   = 36;                  // Q.15 after rounding
   localparam int NUM_W = L_W + FOCAL_W + 1;   // numerator times focal scale
   localparam int DEN_W = L_W - 1;             // positive depth
   localparam int QB    = 18;                  // quotient bits kept before saturation

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_CAMERA_X      = 3'd0,
      CFG_CAMERA_Y      = 3'd1,
      CFG_CAMERA_Z      = 3'd2,
      CFG_YAW           = 3'd3,
      CFG_PITCH         = 3'd4,
      CFG_SCREEN_WIDTH  = 3'd5,
      CFG_SCREEN_HEIGHT = 3'd6
   } cfg_index_type;

   // sign of the relative coordinate, used for the behind-camera markers
   typedef struct packed {
      logic behind;
      logic x_pos;
      logic x_neg;
      logic y_pos;
      logic y_neg;
   } mark_type;

   localparam int MARK_W = $bits(mark_type);

   localparam logic signed [TRIG_W-1:0] SIN_TABLE [0:90] = '{
      16'sd0, 16'sd572, 16'sd1144, 16'sd1715, 16'sd2286, 16'sd2856, 16'sd3425,
      16'sd3993, 16'sd4560, 16'sd5126, 16'sd5690, 16'sd6252, 16'sd6813, 16'sd7371,
      16'sd7927, 16'sd8481, 16'sd9032, 16'sd9580, 16'sd10126, 16'sd10668,
      16'sd11207, 16'sd11743, 16'sd12275, 16'sd12803, 16'sd13328, 16'sd13848,
      16'sd14365, 16'sd14876, 16'sd15384, 16'sd15886, 16'sd16384, 16'sd16877,
      16'sd17364, 16'sd17847, 16'sd18324, 16'sd18795, 16'sd19261, 16'sd19720,
      16'sd20174, 16'sd20622, 16'sd21063, 16'sd21498, 16'sd21926, 16'sd22348,
      16'sd22763, 16'sd23170, 16'sd23571, 16'sd23965, 16'sd24351, 16'sd24730,
      16'sd25102, 16'sd25466, 16'sd25822, 16'sd26170, 16'sd26510, 16'sd26842,
      16'sd27166, 16'sd27482, 16'sd27789, 16'sd28088, 16'sd28378, 16'sd28660,
      16'sd28932, 16'sd29197, 16'sd29452, 16'sd29698, 16'sd29935, 16'sd30163,
      16'sd30382, 16'sd30592, 16'sd30792, 16'sd30983, 16'sd31164, 16'sd31336,
      16'sd31499, 16'sd31651, 16'sd31795, 16'sd31928, 16'sd32052, 16'sd32166,
      16'sd32270, 16'sd32365, 16'sd32449, 16'sd32524, 16'sd32588, 16'sd32643,
      16'sd32688, 16'sd32723, 16'sd32748, 16'sd32763, 16'sd32767
   };

   function automatic logic [ANGLE_W-1:0] mod360(input logic [ANGLE_W-1:0] deg);
      return (deg >= 9'd360) ? deg - 9'd360 : deg;
   endfunction

   function automatic logic signed [TRIG_W-1:0] sin_q15(input logic [ANGLE_W-1:0] deg);
      logic [ANGLE_W-1:0] d;
      logic [ANGLE_W-1:0] t;
      logic               neg;
      d = mod360(deg);
      if (d <= 9'd90) begin
         t = d;
         neg = 1'b0;
      end else if (d <= 9'd180) begin
         t = 9'd180 - d;
         neg = 1'b0;
      end else if (d <= 9'd270) begin
         t = d - 9'd180;
         neg = 1'b1;
      end else begin
         t = 9'd360 - d;
         neg = 1'b1;
      end
      return neg ? -SIN_TABLE[t[6:0]] : SIN_TABLE[t[6:0]];
   endfunction

   function automatic logic signed [TRIG_W-1:0] cos_q15(input logic [ANGLE_W-1:0] deg);
      return sin_q15(mod360(deg) + 9'd90);
   endfunction

endpackage

// ===== rtl/cpp_divider.sv =====
// ----------------------------------------------------------------------------
// cpp_divider
// Two-lane pipelined restoring divider sharing one divisor. One quotient bit
// per stage; an overflow flag marks quotients that do not fit in QB bits.
// ----------------------------------------------------------------------------
module cpp_divider #(
   parameter int N_W    = cpp_pkg::NUM_W,
   parameter int D_W    = cpp_pkg::DEN_W,
   parameter int QB     = cpp_pkg::QB,
   parameter int SIDE_W = cpp_pkg::MARK_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [N_W-1:0]    in_mag_x,
   input  logic [N_W-1:0]    in_mag_y,
   input  logic [1:0]        in_neg,
   input  logic [D_W-1:0]    in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [QB-1:0]     out_q_x,
   output logic [QB-1:0]     out_q_y,
   output logic [1:0]        out_ovf,
   output logic [1:0]        out_neg,
   output logic [SIDE_W-1:0] out_side
);

   localparam int W = N_W + QB;

   logic              v_ff    [QB+1];
   logic [W-1:0]      rx_ff   [QB+1];
   logic [W-1:0]      ry_ff   [QB+1];
   logic [D_W-1:0]    den_ff  [QB+1];
   logic [QB-1:0]     qx_ff   [QB+1];
   logic [QB-1:0]     qy_ff   [QB+1];
   logic [1:0]        ovf_ff  [QB+1];
   logic [1:0]        neg_ff  [QB+1];
   logic [SIDE_W-1:0] side_ff [QB+1];
   logic              en      [QB+2];

   assign en[QB+1] = out_ready;

   // entry stage: overflow check against the divisor scaled by 2^QB
   logic [W-1:0] den_top;
   assign den_top = W'(in_den) << QB;
   assign en[0]   = !v_ff[0] || en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en[0]) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rx_ff[0]   <= W'(in_mag_x);
         ry_ff[0]   <= W'(in_mag_y);
         den_ff[0]  <= in_den;
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
         ovf_ff[0]  <= {W'(in_mag_y) >= den_top, W'(in_mag_x) >= den_top};
         neg_ff[0]  <= in_neg;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 1; k <= QB; k++) begin : g_stage
      logic [W-1:0] sub;
      logic         gx;
      logic         gy;
      assign sub   = W'(den_ff[k-1]) << (QB - k);
      assign gx    = rx_ff[k-1] >= sub;
      assign gy    = ry_ff[k-1] >= sub;
      assign en[k] = !v_ff[k] || en[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rx_ff[k]   <= gx ? rx_ff[k-1] - sub : rx_ff[k-1];
            ry_ff[k]   <= gy ? ry_ff[k-1] - sub : ry_ff[k-1];
            qx_ff[k]   <= qx_ff[k-1] | (QB'(gx) << (QB - k));
            qy_ff[k]   <= qy_ff[k-1] | (QB'(gy) << (QB - k));
            den_ff[k]  <= den_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[QB];
   assign out_q_x   = qx_ff[QB];
   assign out_q_y   = qy_ff[QB];
   assign out_ovf   = ovf_ff[QB];
   assign out_neg   = neg_ff[QB];
   assign out_side  = side_ff[QB];

endmodule

// ===== rtl/camera_point_projection.sv =====
// ----------------------------------------------------------------------------
// camera_point_projection
// Projects a world point through a yaw/pitch camera onto the screen.
// ----------------------------------------------------------------------------
// Takes one point per clock unless req_stall is high and returns one screen
// coordinate pair per point, in order. There are seven stages for the offset,
// both rotations, focal scaling and sign/magnitude, one overflow-check stage,
// 18 restoring divider stages (one quotient bit each) and the output register.
// Stalls collapse bubbles stage by stage. Camera, angle and screen registers are
// written through the csr_ port; the user must do so while no point is in
// flight, the block does not enforce it. Sin/cos of each angle are looked up into flops.
module camera_point_projection #(
   parameter int FOCAL_SCALE = cpp_pkg::FOCAL_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [cpp_pkg::COORD_W-1:0]    req_point_x,
   input  logic signed [cpp_pkg::COORD_W-1:0]    req_point_y,
   input  logic signed [cpp_pkg::COORD_W-1:0]    req_point_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [cpp_pkg::COORD_W-1:0]    rsp_screen_x,
   output logic signed [cpp_pkg::COORD_W-1:0]    rsp_screen_y,
   input  logic                                  csr_we,
   input  logic [cpp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [cpp_pkg::COORD_W-1:0]           csr_wdata
);

   localparam int REL_W = cpp_pkg::REL_W;
   localparam int TRIG_W = cpp_pkg::TRIG_W;
   localparam int P1_W  = cpp_pkg::P1_W;
   localparam int LX_W  = cpp_pkg::LX_W;
   localparam int P2_W  = cpp_pkg::P2_W;
   localparam int L30_W = cpp_pkg::L30_W;
   localparam int L_W   = cpp_pkg::L_W;
   localparam int NUM_W = cpp_pkg::NUM_W;
   localparam int DEN_W = cpp_pkg::DEN_W;
   localparam int QB    = cpp_pkg::QB;
   localparam int SW    = cpp_pkg::SIZE_W;
   localparam int CW    = cpp_pkg::COORD_W;
   localparam logic signed [cpp_pkg::FOCAL_W:0] FOCAL_S = (cpp_pkg::FOCAL_W + 1)'(FOCAL_SCALE);

   // ---------------- configuration registers ----------------
   logic signed [CW-1:0]              cam_x_ff, cam_y_ff, cam_z_ff;
   logic [cpp_pkg::ANGLE_W-1:0]       yaw_ff, pitch_ff;
   logic [SW-1:0]                     width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff  <= '0;
         cam_y_ff  <= -16'sd10;
         cam_z_ff  <= '0;
         yaw_ff    <= '0;
         pitch_ff  <= '0;
         width_ff  <= '0;
         height_ff <= '0;
      end else if (csr_we) begin
         case (cpp_pkg::cfg_index_type'(csr_index))
            cpp_pkg::CFG_CAMERA_X:      cam_x_ff  <= csr_wdata;
            cpp_pkg::CFG_CAMERA_Y:      cam_y_ff  <= csr_wdata;
            cpp_pkg::CFG_CAMERA_Z:      cam_z_ff  <= csr_wdata;
            cpp_pkg::CFG_YAW:           yaw_ff    <= csr_wdata[cpp_pkg::ANGLE_W-1:0];
            cpp_pkg::CFG_PITCH:         pitch_ff  <= csr_wdata[cpp_pkg::ANGLE_W-1:0];
            cpp_pkg::CFG_SCREEN_WIDTH:  width_ff  <= csr_wdata[SW-1:0];
            cpp_pkg::CFG_SCREEN_HEIGHT: height_ff <= csr_wdata[SW-1:0];
            default: ;
         endcase
      end
   end

   logic signed [TRIG_W-1:0] sy_ff, cy_ff, sp_ff, cp_ff;

   always_ff @(posedge clock) begin
      sy_ff <= cpp_pkg::sin_q15(yaw_ff);
      cy_ff <= cpp_pkg::cos_q15(yaw_ff);
      sp_ff <= cpp_pkg::sin_q15(pitch_ff);
      cp_ff <= cpp_pkg::cos_q15(pitch_ff);
   end

   // ---------------- pipeline control ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic e1, e2, e3, e4, e5, e6, e7, e_out;
   logic div_ready;
   logic div_valid;
   logic rsp_valid_ff;

   assign e_out = !rsp_valid_ff || !rsp_stall;
   assign e7 = !v7_ff || div_ready;
   assign e6 = !v6_ff || e7;
   assign e5 = !v5_ff || e6;
   assign e4 = !v4_ff || e5;
   assign e3 = !v3_ff || e4;
   assign e2 = !v2_ff || e3;
   assign e1 = !v1_ff || e2;
   assign req_stall = !e1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (e1) v1_ff <= req_valid;
         if (e2) v2_ff <= v1_ff;
         if (e3) v3_ff <= v2_ff;
         if (e4) v4_ff <= v3_ff;
         if (e5) v5_ff <= v4_ff;
         if (e6) v6_ff <= v5_ff;
         if (e7) v7_ff <= v6_ff;
      end
   end

   // ---------------- stage 1: offset from camera ----------------
   logic signed [REL_W-1:0] rx_in, ry_in, rz_in;
   logic signed [REL_W-1:0] rx1_ff, ry1_ff, rz1_ff;
   cpp_pkg::mark_type       mk_in, mk1_ff, mk2_ff, mk3_ff, mk4_ff, mk5_ff, mk6_ff, mk7_ff;

   assign rx_in = REL_W'(req_point_x) - REL_W'(cam_x_ff);
   assign ry_in = REL_W'(req_point_y) - REL_W'(cam_y_ff);
   assign rz_in = REL_W'(req_point_z) - REL_W'(cam_z_ff);

   always_comb begin
      mk_in        = '0;
      mk_in.x_pos  = !rx_in[REL_W-1] && (rx_in != '0);
      mk_in.x_neg  = rx_in[REL_W-1];
      mk_in.y_pos  = !ry_in[REL_W-1] && (ry_in != '0);
      mk_in.y_neg  = ry_in[REL_W-1];
   end

   always_ff @(posedge clock) begin
      if (e1) begin
         rx1_ff <= rx_in;
         ry1_ff <= ry_in;
         rz1_ff <= rz_in;
         mk1_ff <= mk_in;
      end
   end

   // ---------------- stage 2: yaw products ----------------
   logic signed [P1_W-1:0]  pxc2_ff, pzs2_ff, pxs2_ff, pzc2_ff;
   logic signed [REL_W-1:0] ry2_ff;

   always_ff @(posedge clock) begin
      if (e2) begin
         pxc2_ff <= rx1_ff * cy_ff;
         pzs2_ff <= rz1_ff * sy_ff;
         pxs2_ff <= rx1_ff * sy_ff;
         pzc2_ff <= rz1_ff * cy_ff;
         ry2_ff  <= ry1_ff;
         mk2_ff  <= mk1_ff;
      end
   end

   // ---------------- stage 3: yaw sums ----------------
   logic signed [LX_W-1:0]  lx3_ff, zt3_ff;
   logic signed [REL_W-1:0] ry3_ff;

   always_ff @(posedge clock) begin
      if (e3) begin
         lx3_ff <= LX_W'(pxc2_ff) - LX_W'(pzs2_ff);
         zt3_ff <= LX_W'(pxs2_ff) + LX_W'(pzc2_ff);
         ry3_ff <= ry2_ff;
         mk3_ff <= mk2_ff;
      end
   end

   // ---------------- stage 4: pitch products ----------------
   logic signed [P2_W-1:0] ztsp4_ff, ztcp4_ff;
   logic signed [P1_W-1:0] rycp4_ff, rysp4_ff;
   logic signed [LX_W-1:0] lx4_ff;

   always_ff @(posedge clock) begin
      if (e4) begin
         ztsp4_ff <= zt3_ff * sp_ff;
         ztcp4_ff <= zt3_ff * cp_ff;
         rycp4_ff <= ry3_ff * cp_ff;
         rysp4_ff <= ry3_ff * sp_ff;
         lx4_ff   <= lx3_ff;
         mk4_ff   <= mk3_ff;
      end
   end

   // ---------------- stage 5: pitch sums, round to Q.15 ----------------
   logic signed [L30_W-1:0] ly30, lz30;
   logic signed [L_W-1:0]   ly5_ff, lz5_ff, lx5_ff;

   assign ly30 = (L30_W'(rycp4_ff) <<< 15) - L30_W'(ztsp4_ff) + L30_W'(16384);
   assign lz30 = (L30_W'(rysp4_ff) <<< 15) + L30_W'(ztcp4_ff) + L30_W'(16384);

   always_ff @(posedge clock) begin
      if (e5) begin
         ly5_ff <= ly30[15 +: L_W];
         lz5_ff <= lz30[15 +: L_W];
         lx5_ff <= L_W'(lx4_ff);
         mk5_ff <= mk4_ff;
      end
   end

   // ---------------- stage 6: focal scaling ----------------
   logic signed [NUM_W-1:0] nx6_ff, ny6_ff;
   logic [DEN_W-1:0]        den6_ff;
   cpp_pkg::mark_type       mk6_in;

   always_comb begin
      mk6_in        = mk5_ff;
      mk6_in.behind = lz5_ff[L_W-1] || (lz5_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (e6) begin
         nx6_ff  <= lx5_ff * FOCAL_S;
         ny6_ff  <= ly5_ff * FOCAL_S;
         den6_ff <= lz5_ff[DEN_W-1:0];
         mk6_ff  <= mk6_in;
      end
   end

   // ---------------- stage 7: sign and magnitude ----------------
   logic [NUM_W-1:0] mx7_ff, my7_ff;
   logic [1:0]       neg7_ff;
   logic [DEN_W-1:0] den7_ff;

   always_ff @(posedge clock) begin
      if (e7) begin
         mx7_ff  <= nx6_ff[NUM_W-1] ? NUM_W'(-nx6_ff) : NUM_W'(nx6_ff);
         my7_ff  <= ny6_ff[NUM_W-1] ? NUM_W'(-ny6_ff) : NUM_W'(ny6_ff);
         neg7_ff <= {ny6_ff[NUM_W-1], nx6_ff[NUM_W-1]};
         den7_ff <= den6_ff;
         mk7_ff  <= mk6_ff;
      end
   end

   // ---------------- divider ----------------
   logic [QB-1:0]     qx, qy;
   logic [1:0]        d_ovf, d_neg;
   logic [cpp_pkg::MARK_W-1:0] d_side;
   cpp_pkg::mark_type mk_out;

   cpp_divider #(
      .N_W    (NUM_W),
      .D_W    (DEN_W),
      .QB     (QB),
      .SIDE_W (cpp_pkg::MARK_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v7_ff),
      .in_ready  (div_ready),
      .in_mag_x  (mx7_ff),
      .in_mag_y  (my7_ff),
      .in_neg    (neg7_ff),
      .in_den    (den7_ff),
      .in_side   (mk7_ff),
      .out_valid (div_valid),
      .out_ready (e_out),
      .out_q_x   (qx),
      .out_q_y   (qy),
      .out_ovf   (d_ovf),
      .out_neg   (d_neg),
      .out_side  (d_side)
   );

   assign mk_out = cpp_pkg::mark_type'(d_side);

   // ---------------- output ----------------
   function automatic logic signed [CW-1:0] axis_out(
      input logic [QB-1:0] q,
      input logic          ovf,
      input logic          neg,
      input logic [SW-1:0] size,
      input logic          behind,
      input logic          mpos,
      input logic          mneg
   );
      logic [SW-1:0]          half;
      logic signed [QB+1:0]   qs;
      logic signed [QB+2:0]   sum;
      logic signed [CW-1:0]   r;
      half = size >> 1;
      qs   = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
      sum  = (QB+3)'(qs) + (QB+3)'($signed({1'b0, half}));
      if (behind) begin
         if (mpos)      r = CW'(size) + 16'sd1;
         else if (mneg) r = -16'sd1;
         else           r = CW'(half);
      end else if (ovf) begin
         r = neg ? -16'sd32768 : 16'sd32767;
      end else if (sum > (QB+3)'(32767)) begin
         r = 16'sd32767;
      end else if (sum < -(QB+3)'(32768)) begin
         r = -16'sd32768;
      end else begin
         r = sum[CW-1:0];
      end
      return r;
   endfunction

   logic signed [CW-1:0] sx_ff, sy_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (e_out) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (e_out) begin
         sx_ff     <= axis_out(qx, d_ovf[0], d_neg[0], width_ff, mk_out.behind,
                               mk_out.x_pos, mk_out.x_neg);
         sy_out_ff <= axis_out(qy, d_ovf[1], d_neg[1], height_ff, mk_out.behind,
                               mk_out.y_pos, mk_out.y_neg);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_screen_x = sx_ff;
   assign rsp_screen_y = sy_out_ff;

endmodule
